@@ sv/swc_pkg.sv @@
// ----------------------------------------------------------------------------
// swc_pkg
// Shared types and codes for the sector write coalescer.
// ----------------------------------------------------------------------------
package swc_pkg;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned CountW = 16;
  localparam int unsigned OffW   = 7;

  // request kinds
  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_CLOSE = 2'd2;

  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_FLUSH  = 3'd1,
    CMD_DIRECT = 3'd2,
    CMD_APPEND = 3'd3,
    CMD_READ   = 3'd4
  } cmd_e;

  typedef struct packed {
    cmd_e              command;
    logic [AddrW-1:0]  addr;
    logic [CountW-1:0] count;
    logic [OffW-1:0]   offset;
  } cmd_t;

  // Commands caused by one request; c1 is used only when two is set.
  typedef struct packed {
    logic two;
    cmd_t c0;
    cmd_t c1;
  } plan_t;

endpackage

@@ sv/swc_front.sv @@
// ----------------------------------------------------------------------------
// swc_front
// Accepts requests, tracks the buffered run and classifies each request
// into one or two device commands.
// ----------------------------------------------------------------------------
module swc_front import swc_pkg::*; #(
  parameter int unsigned BUFFER_SECTORS = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              in_fire_i,
  input  logic [1:0]        action_i,
  input  logic [AddrW-1:0]  block_addr_i,
  input  logic [CountW-1:0] block_count_i,
  output plan_t             plan_o
);

  localparam int unsigned CntW = $clog2(BUFFER_SECTORS + 1);
  localparam logic [CountW:0] BufSec = (CountW + 1)'(BUFFER_SECTORS);

  logic              enabled_q;
  logic [AddrW-1:0]  run_start_q, run_start_d;
  logic [CntW-1:0]   run_count_q, run_count_d;
  logic [AddrW:0]    run_end_q, run_end_d;

  logic              nonempty;
  logic [CountW:0]   sum;
  logic [CountW:0]   cnt_ext;
  logic [AddrW:0]    addr_ext;
  logic [AddrW:0]    req_end;
  logic              overlap;
  logic              can_append;
  cmd_t              flush_cmd;
  cmd_t              req_cmd;

  assign nonempty = (run_count_q != '0);
  assign cnt_ext  = {1'b0, block_count_i};
  assign sum      = (CountW + 1)'(run_count_q) + cnt_ext;
  assign addr_ext = {1'b0, block_addr_i};
  assign req_end  = addr_ext + (AddrW + 1)'(block_count_i);
  // zero-length read strictly inside the run still overlaps
  assign overlap  = nonempty && (addr_ext < run_end_q) &&
                    (req_end > {1'b0, run_start_q});
  assign can_append = nonempty && (addr_ext == run_end_q) && (sum <= BufSec);

  assign flush_cmd = '{command: CMD_FLUSH, addr: run_start_q,
                       count: CountW'(run_count_q), offset: '0};
  assign req_cmd   = '{command: CMD_APPEND, addr: block_addr_i,
                       count: block_count_i, offset: '0};

  always_comb begin
    plan_o      = '{two: 1'b0, c0: req_cmd, c1: req_cmd};
    run_start_d = run_start_q;
    run_count_d = run_count_q;
    run_end_d   = run_end_q;
    unique case (action_i)
      ACT_READ: begin
        plan_o.c1.command = CMD_READ;
        plan_o.c0.command = CMD_READ;
        if (overlap) begin
          plan_o.two  = 1'b1;
          plan_o.c0   = flush_cmd;
          run_count_d = '0;
          run_end_d   = {1'b0, run_start_q};
        end
      end
      ACT_WRITE: begin
        if (enabled_q && can_append) begin
          plan_o.c0.offset = OffW'(run_count_q);
          if (sum >= BufSec) begin
            plan_o.two          = 1'b1;
            plan_o.c1           = flush_cmd;
            plan_o.c1.count     = CountW'(sum);
            run_count_d         = '0;
            run_end_d           = {1'b0, run_start_q};
          end else begin
            run_count_d = CntW'(sum);
            run_end_d   = req_end;
          end
        end else begin
          plan_o.c1 = req_cmd;
          if (!enabled_q || cnt_ext >= BufSec) begin
            plan_o.c1.command = CMD_DIRECT;
            run_count_d       = '0;
            run_end_d         = {1'b0, run_start_q};
          end else begin
            run_start_d = block_addr_i;
            run_count_d = CntW'(block_count_i);
            run_end_d   = req_end;
          end
          if (nonempty) begin
            plan_o.two = 1'b1;
            plan_o.c0  = flush_cmd;
          end else begin
            plan_o.c0 = plan_o.c1;
          end
        end
      end
      default: begin
        plan_o.c0 = '{command: CMD_NONE, addr: '0, count: '0, offset: '0};
        if (action_i == ACT_CLOSE && nonempty) begin
          plan_o.c0   = flush_cmd;
          run_count_d = '0;
          run_end_d   = {1'b0, run_start_q};
        end
        plan_o.c1 = plan_o.c0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q   <= 1'b1;
      run_start_q <= '0;
      run_count_q <= '0;
      run_end_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        enabled_q <= cfg_wdata_i;
      end
      if (in_fire_i) begin
        run_start_q <= run_start_d;
        run_count_q <= run_count_d;
        run_end_q   <= run_end_d;
      end
    end
  end

endmodule

@@ sv/swc_queue.sv @@
// ----------------------------------------------------------------------------
// swc_queue
// Two-entry queue of command plans between front and back.
// ----------------------------------------------------------------------------
module swc_queue import swc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  plan_t push_plan_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output plan_t head_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned FillW = $clog2(Depth + 1);

  plan_t            mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [FillW-1:0] fill_q;

  assign full_o  = (fill_q == FillW'(Depth));
  assign valid_o = (fill_q != '0);
  assign head_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_plan_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

@@ sv/swc_back.sv @@
// ----------------------------------------------------------------------------
// swc_back
// Walks the queued plan one command per cycle into the output register while the output is not stalled.
// ----------------------------------------------------------------------------
module swc_back import swc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  plan_t             q_head_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        command_o,
  output logic [AddrW-1:0]  cmd_addr_o,
  output logic [CountW-1:0] cmd_count_o,
  output logic [OffW-1:0]   buffer_offset_o,
  output logic              last_o
);

  logic   phase_q;
  logic   out_valid_q;
  cmd_t   out_cmd_q;
  logic   out_last_q;
  logic   load;
  logic   is_last;
  cmd_t   sel_cmd;

  assign load    = (!out_valid_q || !out_stall_i) && q_valid_i;
  assign sel_cmd = phase_q ? q_head_i.c1 : q_head_i.c0;
  assign is_last = phase_q || !q_head_i.two;
  assign q_pop_o = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        phase_q     <= !is_last;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_cmd_q  <= sel_cmd;
      out_last_q <= is_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign command_o       = out_cmd_q.command;
  assign cmd_addr_o      = out_cmd_q.addr;
  assign cmd_count_o     = out_cmd_q.count;
  assign buffer_offset_o = out_cmd_q.offset;
  assign last_o          = out_last_q;

endmodule

@@ sv/sector_write_coalescer.sv @@
// ----------------------------------------------------------------------------
// sector_write_coalescer
// Write-combining front end for a sector device: turns block requests into
// flush, direct write, append and read commands.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  in        in_valid_i/in_stall_o  action_i, block_addr_i, block_count_i
//  out       out_valid_o/out_stall_i command_o, cmd_addr_o, cmd_count_o,
//                                   buffer_offset_o, last_o
//  cfg       cfg_we_i               cfg_wdata_i (buffer_enabled)
//
// A request is classified in its accept cycle and emits 1 or 2 commands, one
// per cycle from the output register while the output is not stalled. The plan
// is pushed into the plan queue when the request is accepted, and its first
// command is then loaded from the queue head into the output register. The
// two-entry plan queue stalls input only when full. Reset empties the run and
// sets buffer_enabled.
// ----------------------------------------------------------------------------
module sector_write_coalescer import swc_pkg::*; #(
  parameter int unsigned BUFFER_SECTORS = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        action_i,
  input  logic [AddrW-1:0]  block_addr_i,
  input  logic [CountW-1:0] block_count_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        command_o,
  output logic [AddrW-1:0]  cmd_addr_o,
  output logic [CountW-1:0] cmd_count_o,
  output logic [OffW-1:0]   buffer_offset_o,
  output logic              last_o
);

  logic  in_fire;
  logic  q_full;
  logic  q_valid;
  logic  q_pop;
  plan_t plan;
  plan_t head;

  assign in_stall_o = q_full;
  assign in_fire    = in_valid_i && !q_full;

  swc_front #(
    .BUFFER_SECTORS(BUFFER_SECTORS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_fire_i     (in_fire),
    .action_i      (action_i),
    .block_addr_i  (block_addr_i),
    .block_count_i (block_count_i),
    .plan_o        (plan)
  );

  swc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_fire),
    .push_plan_i (plan),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (head)
  );

  swc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_head_i        (head),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .command_o       (command_o),
    .cmd_addr_o      (cmd_addr_o),
    .cmd_count_o     (cmd_count_o),
    .buffer_offset_o (buffer_offset_o),
    .last_o          (last_o)
  );

endmodule
